/* design/assert_macros.svh */
// assertion macros shared by the symbol table modules
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/ssym_pkg.sv */
// shared types and codes for the scoped symbol table
// no dependencies; used by the controller, datapath and top level
package ssym_pkg;

    localparam int FIELD_W = 64;
    localparam int REQ_W   = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 3'd0,
        REQ_POP    = 3'd1,
        REQ_SET    = 3'd2,
        REQ_UPDATE = 3'd3,
        REQ_GET    = 3'd4,
        REQ_EXISTS = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_STACK_FULL = 2'd1,
        ST_POP_GLOBAL = 2'd2,
        ST_SCOPE_FULL = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_WAIT,
        S_SCAN,
        S_CNT_WAIT,
        S_CMP,
        S_NOMATCH,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    latch_req;
        logic    push;
        logic    pop;
        logic    pop_load;
        logic    search_init;
        logic    scope_down;
        logic    cnt_load;
        logic    idx_inc;
        logic    write_match;
        logic    append;
        logic    res_found;
        logic    res_take_value;
        logic    res_set_status;
        status_t res_status;
        logic    load_out;
    } ssym_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             top_full;
        logic             top_global;
        logic             idx_end;
        logic             scope_bottom;
        logic             key_hit;
        logic             scope_full;
        logic             out_busy;
    } ssym_sts_t;

endpackage

/* design/scoped_symbol_table.sv */
// scoped symbol table: one beat in, one result beat out, one request at a time
// push and undefined codes go from dispatch to the final state; pop adds a wait state
// for the saved count; set/update/get/exists alternate scan and compare states per entry,
// add a count-wait state per lower scope entered and a no-match state; registered key read
// a stalled result holds the block in its final state; next beat taken as the result shows
// rst_n clears the stack to the global scope with no entries; memories need no clearing
module scoped_symbol_table #(
    parameter int MAX_SCOPES            = 16,
    parameter int MAX_ENTRIES_PER_SCOPE = 32,
    parameter int KEY_BITS              = 64,
    parameter int VALUE_BITS            = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ssym_pkg::REQ_W-1:0]          req_type,
    input  logic [ssym_pkg::FIELD_W-1:0]        key,
    input  logic [ssym_pkg::FIELD_W-1:0]        write_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic [ssym_pkg::FIELD_W-1:0]        read_value,
    output logic [1:0]                          status
);

    ssym_pkg::ssym_cmd_t cmd;
    ssym_pkg::ssym_sts_t sts;

    ssym_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssym_dp #(
        .MAX_SCOPES            (MAX_SCOPES),
        .MAX_ENTRIES_PER_SCOPE (MAX_ENTRIES_PER_SCOPE),
        .KEY_BITS              (KEY_BITS),
        .VALUE_BITS            (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .key         (key),
        .write_value (write_value),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .found       (found),
        .read_value  (read_value),
        .status      (status)
    );

endmodule

/* design/ssym_ram.sv */
// generic single-port ram with registered read
// no dependencies; used for key, value and scope count storage
module ssym_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                            wdata,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/ssym_ctrl.sv */
// controller state machine for the scoped symbol table
// depends on ssym_pkg and assert_macros.svh
`include "assert_macros.svh"

module ssym_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ssym_pkg::ssym_sts_t  sts,
    output ssym_pkg::ssym_cmd_t  cmd
);

    ssym_pkg::state_t state_reg;
    ssym_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssym_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ssym_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = ssym_pkg::S_DISPATCH;
                end
            end
            ssym_pkg::S_DISPATCH:
            begin
                case (sts.req)
                    ssym_pkg::REQ_PUSH:
                    begin
                        if (sts.top_full)
                        begin
                            cmd.res_set_status = 1'b1;
                            cmd.res_status     = ssym_pkg::ST_STACK_FULL;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                        state_next = ssym_pkg::S_FINISH;
                    end
                    ssym_pkg::REQ_POP:
                    begin
                        if (sts.top_global)
                        begin
                            cmd.res_set_status = 1'b1;
                            cmd.res_status     = ssym_pkg::ST_POP_GLOBAL;
                            state_next         = ssym_pkg::S_FINISH;
                        end
                        else
                        begin
                            cmd.pop    = 1'b1;
                            state_next = ssym_pkg::S_POP_WAIT;
                        end
                    end
                    ssym_pkg::REQ_SET, ssym_pkg::REQ_UPDATE,
                    ssym_pkg::REQ_GET, ssym_pkg::REQ_EXISTS:
                    begin
                        cmd.search_init = 1'b1;
                        state_next      = ssym_pkg::S_SCAN;
                    end
                    default:
                    begin
                        state_next = ssym_pkg::S_FINISH;
                    end
                endcase
            end
            ssym_pkg::S_POP_WAIT:
            begin
                cmd.pop_load = 1'b1;
                state_next   = ssym_pkg::S_FINISH;
            end
            ssym_pkg::S_SCAN:
            begin
                if (sts.idx_end)
                begin
                    // set looks at the top scope only
                    if (sts.req == ssym_pkg::REQ_SET || sts.scope_bottom)
                    begin
                        state_next = ssym_pkg::S_NOMATCH;
                    end
                    else
                    begin
                        cmd.scope_down = 1'b1;
                        state_next     = ssym_pkg::S_CNT_WAIT;
                    end
                end
                else
                begin
                    state_next = ssym_pkg::S_CMP;
                end
            end
            ssym_pkg::S_CNT_WAIT:
            begin
                cmd.cnt_load = 1'b1;
                state_next   = ssym_pkg::S_SCAN;
            end
            ssym_pkg::S_CMP:
            begin
                if (sts.key_hit)
                begin
                    case (sts.req)
                        ssym_pkg::REQ_GET:
                        begin
                            cmd.res_found      = 1'b1;
                            cmd.res_take_value = 1'b1;
                        end
                        ssym_pkg::REQ_EXISTS:
                        begin
                            cmd.res_found = 1'b1;
                        end
                        default:
                        begin
                            cmd.write_match = 1'b1;
                        end
                    endcase
                    state_next = ssym_pkg::S_FINISH;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ssym_pkg::S_SCAN;
                end
            end
            ssym_pkg::S_NOMATCH:
            begin
                if (sts.req inside {ssym_pkg::REQ_SET, ssym_pkg::REQ_UPDATE})
                begin
                    if (sts.scope_full)
                    begin
                        cmd.res_set_status = 1'b1;
                        cmd.res_status     = ssym_pkg::ST_SCOPE_FULL;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                    end
                end
                state_next = ssym_pkg::S_FINISH;
            end
            ssym_pkg::S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ssym_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ssym_pkg::S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ssym_pkg::S_IDLE);

    // a compare always follows a key read issued from the scan state
    `ASSERT_IMPLIES(a_cmp_after_scan, clk, rst_n, state_reg == ssym_pkg::S_CMP, $past(state_reg) == ssym_pkg::S_SCAN)
    // a new beat is only taken after the result was handed to the output stage
    `ASSERT_IMPLIES(a_idle_after_finish, clk, rst_n, $fell(in_stall), $past(state_reg) == ssym_pkg::S_FINISH)
    // the output stage is only loaded from the final state
    `ASSERT_IMPLIES(a_load_in_finish, clk, rst_n, cmd.load_out, state_reg == ssym_pkg::S_FINISH)

endmodule

/* design/ssym_dp.sv */
// datapath: scope stack registers, key/value/count memories, result staging
// depends on ssym_pkg, ssym_ram and assert_macros.svh
`include "assert_macros.svh"

module ssym_dp #(
    parameter int MAX_SCOPES            = 16,
    parameter int MAX_ENTRIES_PER_SCOPE = 32,
    parameter int KEY_BITS              = 64,
    parameter int VALUE_BITS            = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ssym_pkg::ssym_cmd_t                   cmd,
    output ssym_pkg::ssym_sts_t                   sts,
    input  logic [ssym_pkg::REQ_W-1:0]            req_type,
    input  logic [ssym_pkg::FIELD_W-1:0]          key,
    input  logic [ssym_pkg::FIELD_W-1:0]          write_value,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic                                  found,
    output logic [ssym_pkg::FIELD_W-1:0]          read_value,
    output logic [1:0]                            status
);

    localparam int SLOTS   = MAX_SCOPES * MAX_ENTRIES_PER_SCOPE;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCOPE_W = (MAX_SCOPES > 1) ? $clog2(MAX_SCOPES) : 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES_PER_SCOPE + 1);

    // stack position and scan registers
    logic [SCOPE_W-1:0] top_reg, top_next;
    logic [SLOT_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]   top_count_reg, top_count_next;
    logic [SCOPE_W-1:0] scope_reg, scope_next;
    logic [SLOT_W-1:0]  sbase_reg, sbase_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;

    // request and result payload
    logic [ssym_pkg::REQ_W-1:0] req_reg;
    logic [KEY_BITS-1:0]        req_key_reg;
    logic [VALUE_BITS-1:0]      req_value_reg;
    logic                       res_found_reg;
    logic [VALUE_BITS-1:0]      res_value_reg;
    ssym_pkg::status_t          res_status_reg;
    logic                       found_reg;
    logic [VALUE_BITS-1:0]      read_value_reg;
    ssym_pkg::status_t          status_reg;

    logic [SLOT_W-1:0]     scan_addr;
    logic [SLOT_W-1:0]     app_addr;
    logic [SLOT_W-1:0]     mem_addr;
    logic [SCOPE_W-1:0]    cnt_addr;
    logic [KEY_BITS-1:0]   key_rdata;
    logic [VALUE_BITS-1:0] value_rdata;
    logic [CNT_W-1:0]      cnt_rdata;

    assign scan_addr = sbase_reg + SLOT_W'(idx_reg);
    assign app_addr  = base_reg + SLOT_W'(top_count_reg);
    assign mem_addr  = cmd.append ? app_addr : scan_addr;

    // push saves the count of the scope below; pop and scope steps read it back
    always_comb
    begin
        if (cmd.push)
        begin
            cnt_addr = top_reg;
        end
        else if (cmd.pop)
        begin
            cnt_addr = top_reg - SCOPE_W'(1);
        end
        else
        begin
            cnt_addr = scope_reg - SCOPE_W'(1);
        end
    end

    ssym_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (cmd.append),
        .addr  (mem_addr),
        .wdata (req_key_reg),
        .rdata (key_rdata)
    );

    ssym_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SLOTS)
    ) u_value_ram (
        .clk   (clk),
        .we    (cmd.append | cmd.write_match),
        .addr  (mem_addr),
        .wdata (req_value_reg),
        .rdata (value_rdata)
    );

    ssym_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_SCOPES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cmd.push),
        .addr  (cnt_addr),
        .wdata (top_count_reg),
        .rdata (cnt_rdata)
    );

    always_comb
    begin
        top_next       = top_reg;
        base_next      = base_reg;
        top_count_next = top_count_reg;
        scope_next     = scope_reg;
        sbase_next     = sbase_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;

        if (cmd.push)
        begin
            top_next       = top_reg + SCOPE_W'(1);
            base_next      = base_reg + SLOT_W'(MAX_ENTRIES_PER_SCOPE);
            top_count_next = '0;
        end
        if (cmd.pop)
        begin
            top_next  = top_reg - SCOPE_W'(1);
            base_next = base_reg - SLOT_W'(MAX_ENTRIES_PER_SCOPE);
        end
        if (cmd.pop_load)
        begin
            top_count_next = cnt_rdata;
        end
        if (cmd.append)
        begin
            top_count_next = top_count_reg + CNT_W'(1);
        end
        if (cmd.search_init)
        begin
            scope_next = top_reg;
            sbase_next = base_reg;
            idx_next   = '0;
            cnt_next   = top_count_reg;
        end
        if (cmd.scope_down)
        begin
            scope_next = scope_reg - SCOPE_W'(1);
            sbase_next = sbase_reg - SLOT_W'(MAX_ENTRIES_PER_SCOPE);
            idx_next   = '0;
        end
        if (cmd.cnt_load)
        begin
            cnt_next = cnt_rdata;
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            base_reg      <= '0;
            top_count_reg <= '0;
            scope_reg     <= '0;
            sbase_reg     <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg       <= top_next;
            base_reg      <= base_next;
            top_count_reg <= top_count_next;
            scope_reg     <= scope_next;
            sbase_reg     <= sbase_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_reg        <= req_type;
            req_key_reg    <= key[KEY_BITS-1:0];
            req_value_reg  <= write_value[VALUE_BITS-1:0];
            res_found_reg  <= 1'b0;
            res_value_reg  <= '0;
            res_status_reg <= ssym_pkg::ST_OK;
        end
        else
        begin
            if (cmd.res_found)
            begin
                res_found_reg <= 1'b1;
            end
            if (cmd.res_take_value)
            begin
                res_value_reg <= value_rdata;
            end
            if (cmd.res_set_status)
            begin
                res_status_reg <= cmd.res_status;
            end
        end

        if (cmd.load_out)
        begin
            found_reg      <= res_found_reg;
            read_value_reg <= res_value_reg;
            status_reg     <= res_status_reg;
        end
    end

    assign sts.req          = req_reg;
    assign sts.top_full     = (top_reg == SCOPE_W'(MAX_SCOPES - 1));
    assign sts.top_global   = (top_reg == '0);
    assign sts.idx_end      = (idx_reg == cnt_reg);
    assign sts.scope_bottom = (scope_reg == '0);
    assign sts.key_hit      = (key_rdata == req_key_reg);
    assign sts.scope_full   = (top_count_reg == CNT_W'(MAX_ENTRIES_PER_SCOPE));
    assign sts.out_busy     = out_valid_reg & out_stall;

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign read_value = ssym_pkg::FIELD_W'(read_value_reg);
    assign status     = status_reg;

    // the top scope never holds more entries than it has room for
    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, top_count_reg <= CNT_W'(MAX_ENTRIES_PER_SCOPE))
    // a freshly pushed scope starts empty
    `ASSERT_NEXT(a_push_clears, clk, rst_n, cmd.push, top_count_reg == '0)
    // the scan index never runs past the count of the scope it walks
    `ASSERT_IMPLIES(a_idx_bound, clk, rst_n, 1'b1, idx_reg <= cnt_reg)

endmodule
